[rtl/ct_pkg.sv]
package ct_pkg;

    // Default number of columns the block supports.
    localparam int MAX_KEY_DEF = 16;

    // Configuration register widths.
    localparam int CFG_DATA_W = 64;
    localparam int CFG_ADDR_W = 5;
    localparam int KEY_LEN_W  = 5;

    // Payload widths.
    localparam int SYM_W = 8;

    // Register indexes on the configuration port (byte address = 8 * index).
    typedef enum logic [1:0] {
        CFG_KEY_LOW  = 2'd0,
        CFG_KEY_HIGH = 2'd1,
        CFG_KEY_LEN  = 2'd2,
        CFG_DIR      = 2'd3
    } t_cfg_idx;

endpackage

[rtl/ct_row_mem.sv]
module ct_row_mem import ct_pkg::*; #(
    parameter int DEPTH = MAX_KEY_DEF,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [SYM_W-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [SYM_W-1:0] o_rdata
);

    logic [SYM_W-1:0] r_mem [DEPTH];
    logic [SYM_W-1:0] r_rdata;

    // One write port, one registered read port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

[rtl/ct_order.sv]
module ct_order import ct_pkg::*; #(
    parameter int MAX_KEY = MAX_KEY_DEF,
    localparam int AW     = $clog2(MAX_KEY),
    localparam int NW     = $clog2(MAX_KEY + 1)
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic [CFG_DATA_W-1:0] i_key_low,
    input  logic [CFG_DATA_W-1:0] i_key_high,
    input  logic [NW-1:0]         i_width,
    input  logic                  i_dir,
    input  logic                  i_start,
    input  logic [AW-1:0]         i_rd_addr,
    output logic [AW-1:0]         o_rd_data,
    output logic                  o_ready
);

    typedef enum logic [2:0] {
        S_LOAD,
        S_FETCH,
        S_COMP,
        S_SWEEP,
        S_DONE
    } t_state;

    t_state r_state;

    // Working key bytes and column order, and the final gather table.
    logic [SYM_W-1:0] r_kb  [MAX_KEY];
    logic [AW-1:0]    r_ord [MAX_KEY];
    logic [AW-1:0]    r_gat [MAX_KEY];

    logic [AW-1:0]    r_i;
    logic [AW-1:0]    r_j;
    logic [SYM_W-1:0] r_ck;
    logic [AW-1:0]    r_co;

    logic [2*CFG_DATA_W-1:0] key_all;
    logic [AW-1:0]           last_idx;
    logic [AW-1:0]           rd_idx;
    logic [SYM_W-1:0]        kb_rd;
    logic [AW-1:0]           ord_rd;
    logic                    swap;
    logic [SYM_W-1:0]        n_ck;
    logic [AW-1:0]           n_co;

    assign key_all  = {i_key_high, i_key_low};
    assign last_idx = AW'(i_width - NW'(1));

    // Single read port into the working arrays: the inner index while
    // comparing, otherwise the outer index (which also walks the sweep).
    assign rd_idx = (r_state == S_COMP) ? r_j : r_i;
    assign kb_rd  = r_kb[rd_idx];
    assign ord_rd = r_ord[rd_idx];

    // Signed byte compare; the held entry moves on when it is larger.
    assign swap = $signed(r_ck) > $signed(kb_rd);
    assign n_ck = swap ? kb_rd  : r_ck;
    assign n_co = swap ? ord_rd : r_co;

    assign o_rd_data = r_gat[i_rd_addr];
    assign o_ready   = (r_state == S_DONE);

    // Exchange sort with one compare-swap a cycle while in the compare state, then the gather sweep.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_LOAD;
            r_i     <= '0;
        end else if (i_start) begin
            r_state <= S_LOAD;
            r_i     <= '0;
        end else begin
            unique case (r_state)
                S_LOAD: begin
                    for (int k = 0; k < MAX_KEY; k++) begin
                        r_kb[k]  <= (k < 16) ? key_all[8*(k%16) +: 8] : '0;
                        r_ord[k] <= AW'(k);
                    end
                    r_i     <= '0;
                    r_state <= (last_idx == '0) ? S_SWEEP : S_FETCH;
                end
                S_FETCH: begin
                    r_ck    <= kb_rd;
                    r_co    <= ord_rd;
                    r_j     <= r_i + AW'(1);
                    r_state <= S_COMP;
                end
                S_COMP: begin
                    if (swap) begin
                        r_kb[r_j]  <= r_ck;
                        r_ord[r_j] <= r_co;
                    end
                    if (r_j == last_idx) begin
                        r_kb[r_i]  <= n_ck;
                        r_ord[r_i] <= n_co;
                        if ((r_i + AW'(1)) < last_idx) begin
                            r_i     <= r_i + AW'(1);
                            r_state <= S_FETCH;
                        end else begin
                            r_i     <= '0;
                            r_state <= S_SWEEP;
                        end
                    end else begin
                        r_ck <= n_ck;
                        r_co <= n_co;
                        r_j  <= r_j + AW'(1);
                    end
                end
                S_SWEEP: begin
                    // Decrypt needs the inverse order, encrypt the order itself.
                    if (i_dir) begin
                        r_gat[ord_rd] <= r_i;
                    end else begin
                        r_gat[r_i] <= ord_rd;
                    end
                    if (r_i == last_idx) begin
                        r_state <= S_DONE;
                    end else begin
                        r_i <= r_i + AW'(1);
                    end
                end
                S_DONE: begin
                    r_state <= S_DONE;
                end
                default: begin
                    r_state <= S_LOAD;
                end
            endcase
        end
    end

endmodule

[rtl/columnar_transposition.sv]
// Channel  | Direction | Transfer carries
// ---------+-----------+------------------------------------------------------
// s_axis   | in        | tdata[7:0] symbol, tlast message_end
// m_axis   | out       | tdata[7:0] out_symbol, tlast row_end, tuser message_done
// apb      | in/out    | 64-bit registers at 8*index: key_low, key_high,
//          |           | key_length, direction
//
// A row of n columns takes up to n input symbols (fewer on message_end); each
// emitted symbol needs the gather-table lookup and the registered row memory
// read, issued once the previous read is in the output register. After reset
// and every write a single compare-swap unit rebuilds the order, input held off.
// Reset is synchronous and active low; a register write discards a partial row.
// Output stalls hold the result register; input waits while a row is emitted.
module columnar_transposition import ct_pkg::*; #(
    parameter int MAX_KEY = MAX_KEY_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // Input stream
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [7:0]            s_axis_tdata,   // [7:0] symbol
    input  logic                  s_axis_tlast,   // message_end
    // Output stream
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    output logic [7:0]            m_axis_tdata,   // [7:0] out_symbol
    output logic                  m_axis_tlast,   // row_end
    output logic                  m_axis_tuser,   // [0] message_done
    // Configuration port
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [CFG_ADDR_W-1:0] paddr,
    input  logic [CFG_DATA_W-1:0] pwdata,
    output logic [CFG_DATA_W-1:0] prdata,
    output logic                  pready
);

    localparam int AW = $clog2(MAX_KEY);
    localparam int NW = $clog2(MAX_KEY + 1);

    typedef enum logic {
        S_FILL,
        S_EMIT
    } t_state;

    // Configuration registers.
    logic [CFG_DATA_W-1:0] r_key_low;
    logic [CFG_DATA_W-1:0] r_key_high;
    logic [KEY_LEN_W-1:0]  r_key_len;
    logic                  r_dir;

    // Row control.
    t_state        r_state;
    logic [AW-1:0] r_cnt;
    logic [NW-1:0] r_fill;
    logic          r_last;
    logic [AW-1:0] r_p;

    // Read in flight and the output register.
    logic             r_pend;
    logic             r_pend_zero;
    logic             r_pend_rend;
    logic             r_pend_done;
    logic             r_out_valid;
    logic [SYM_W-1:0] r_out_data;
    logic             r_out_last;
    logic             r_out_user;

    logic             cfg_wr;
    t_cfg_idx         cfg_idx;
    logic [NW-1:0]    width;
    logic [AW-1:0]    last_idx;
    logic             order_ready;
    logic [AW-1:0]    gat_col;
    logic [SYM_W-1:0] mem_q;
    logic             in_xfer;
    logic [NW-1:0]    cnt_inc;
    logic             row_close;
    logic             issue;
    logic             p_last;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite;
    assign cfg_idx = t_cfg_idx'(paddr[4:3]);

    // Register read-back.
    always_comb begin
        unique case (cfg_idx)
            CFG_KEY_LOW:  prdata = r_key_low;
            CFG_KEY_HIGH: prdata = r_key_high;
            CFG_KEY_LEN:  prdata = CFG_DATA_W'(r_key_len);
            CFG_DIR:      prdata = CFG_DATA_W'(r_dir);
            default:      prdata = '0;
        endcase
    end

    // Row width: zero acts as one, anything beyond the store acts as full width.
    always_comb begin
        if (r_key_len == '0) begin
            width = NW'(1);
        end else if (32'(r_key_len) > MAX_KEY) begin
            width = NW'(MAX_KEY);
        end else begin
            width = NW'(r_key_len);
        end
    end

    assign last_idx = AW'(width - NW'(1));

    // Configuration writes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key_low  <= '0;
            r_key_high <= '0;
            r_key_len  <= KEY_LEN_W'(1);
            r_dir      <= 1'b0;
        end else if (cfg_wr) begin
            unique case (cfg_idx)
                CFG_KEY_LOW:  r_key_low  <= pwdata;
                CFG_KEY_HIGH: r_key_high <= pwdata;
                CFG_KEY_LEN:  r_key_len  <= pwdata[KEY_LEN_W-1:0];
                CFG_DIR:      r_dir      <= pwdata[0];
                default:      r_dir      <= r_dir;
            endcase
        end
    end

    ct_order #(
        .MAX_KEY (MAX_KEY)
    ) u_order (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_key_low  (r_key_low),
        .i_key_high (r_key_high),
        .i_width    (width),
        .i_dir      (r_dir),
        .i_start    (cfg_wr),
        .i_rd_addr  (r_p),
        .o_rd_data  (gat_col),
        .o_ready    (order_ready)
    );

    ct_row_mem #(
        .DEPTH (MAX_KEY)
    ) u_row_mem (
        .i_clk   (i_clk),
        .i_we    (in_xfer),
        .i_waddr (r_cnt),
        .i_wdata (s_axis_tdata),
        .i_raddr (gat_col),
        .o_rdata (mem_q)
    );

    assign s_axis_tready = (r_state == S_FILL) && order_ready;
    assign in_xfer       = s_axis_tvalid && s_axis_tready;
    assign cnt_inc       = NW'(r_cnt) + NW'(1);
    assign row_close     = in_xfer && ((cnt_inc == width) || s_axis_tlast);

    // A read is issued only when the output register is free by the next edge.
    assign issue  = (r_state == S_EMIT) && !r_pend && (!r_out_valid || m_axis_tready);
    assign p_last = (r_p == last_idx);

    // Row fill and emit sequencing.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_FILL;
            r_cnt   <= '0;
            r_p     <= '0;
            r_pend  <= 1'b0;
        end else if (cfg_wr) begin
            r_state <= S_FILL;
            r_cnt   <= '0;
            r_p     <= '0;
            r_pend  <= 1'b0;
        end else begin
            unique case (r_state)
                S_FILL: begin
                    r_pend <= 1'b0;
                    if (row_close) begin
                        r_fill  <= cnt_inc;
                        r_last  <= s_axis_tlast;
                        r_cnt   <= '0;
                        r_p     <= '0;
                        r_state <= S_EMIT;
                    end else if (in_xfer) begin
                        r_cnt <= AW'(cnt_inc);
                    end
                end
                S_EMIT: begin
                    r_pend <= issue;
                    if (issue) begin
                        // Columns past the received symbols read as zero.
                        r_pend_zero <= (NW'(gat_col) >= r_fill);
                        r_pend_rend <= p_last;
                        r_pend_done <= p_last && r_last;
                        if (p_last) begin
                            r_state <= S_FILL;
                        end else begin
                            r_p <= r_p + AW'(1);
                        end
                    end
                end
                default: begin
                    r_state <= S_FILL;
                end
            endcase
        end
    end

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (r_pend) begin
            r_out_valid <= 1'b1;
            r_out_data  <= r_pend_zero ? '0 : mem_q;
            r_out_last  <= r_pend_rend;
            r_out_user  <= r_pend_done;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;
    assign m_axis_tlast  = r_out_last;
    assign m_axis_tuser  = r_out_user;

endmodule

[rtl/ct_checker.sv]
module ct_checker import ct_pkg::*; (
    input logic                  i_clk,
    input logic                  i_rst_n,
    input logic                  s_axis_tvalid,
    input logic                  s_axis_tready,
    input logic [7:0]            s_axis_tdata,
    input logic                  s_axis_tlast,
    input logic                  m_axis_tvalid,
    input logic                  m_axis_tready,
    input logic [7:0]            m_axis_tdata,
    input logic                  m_axis_tlast,
    input logic                  m_axis_tuser,
    input logic                  psel,
    input logic                  penable,
    input logic                  pwrite,
    input logic [CFG_ADDR_W-1:0] paddr,
    input logic [CFG_DATA_W-1:0] pwdata,
    input logic [CFG_DATA_W-1:0] prdata,
    input logic                  pready
);

    // A stalled result keeps its valid and its payload.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast)
            && $stable(m_axis_tuser))
        else $error("output changed while stalled");

    // The end of a message always closes a row.
    a_done_row: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser |-> m_axis_tlast)
        else $error("message_done without row_end");

    // A register write starts an order rebuild, so input is held off next cycle.
    a_cfg_block: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        psel && penable && pwrite && pready |=> !s_axis_tready)
        else $error("input taken during order rebuild");

    // While a row is still being emitted no new symbol is taken.
    a_emit_block: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tlast |-> !s_axis_tready)
        else $error("input taken mid-row");

endmodule

bind columnar_transposition ct_checker u_ct_checker (.*);
